@@ design/odrp_pkg.sv @@
package odrp_pkg;

    localparam int ENTRY_W = 25;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [1:0] EV_CODE_ADDED   = 2'd0;
    localparam logic [1:0] EV_MILEAGE      = 2'd1;
    localparam logic [1:0] EV_VIN_CHAR     = 2'd2;
    localparam logic [1:0] EV_VIN_COMPLETE = 2'd3;

    localparam logic KIND_OBD = 1'b0;
    localparam logic KIND_UDS = 1'b1;

    localparam logic [7:0] SVC_OBD_DATA    = 8'h41;
    localparam logic [7:0] SVC_OBD_DTC     = 8'h43;
    localparam logic [7:0] SVC_VEH_INFO    = 8'h49;
    localparam logic [7:0] SVC_UDS_DTC     = 8'h19;
    localparam logic [7:0] SVC_POS_OFFSET  = 8'h40;
    localparam logic [7:0] PID_ODOMETER    = 8'hA6;
    localparam logic [7:0] INFO_VIN        = 8'h02;
    localparam logic [7:0] UDS_DTC_BY_MASK = 8'h02;
    localparam logic [7:0] VIN_CHAR_LO     = 8'h20;
    localparam logic [7:0] VIN_CHAR_HI     = 8'h7E;

    typedef struct packed {
        logic       op;
        logic [7:0] payload_byte;
        logic       end_of_message;
    } req_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic        code_kind;
        logic [23:0] code_value;
        logic [5:0]  code_total;
        logic [28:0] mileage_value;
        logic [4:0]  vin_position;
        logic [6:0]  vin_character;
        logic [4:0]  vin_count;
        logic        run_last;
    } res_t;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [ENTRY_W-1:0] entry;
    } probe_t;

endpackage

@@ design/odrp_chan_if.sv @@
interface odrp_chan_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/odrp_cell.sv @@
module odrp_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         active,
    input  logic                         wr_en,
    input  logic [odrp_pkg::ENTRY_W-1:0] wr_entry,
    input  odrp_pkg::probe_t             probe_in,
    output odrp_pkg::probe_t             probe_out
);
    import odrp_pkg::*;

    logic [ENTRY_W-1:0] entry_reg;
    probe_t             probe_reg;
    probe_t             probe_next;

    always_comb
    begin
        probe_next       = probe_in;
        probe_next.hit   = probe_in.hit | (active && (entry_reg == probe_in.entry));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
endmodule

@@ design/odrp_div10.sv @@
module odrp_div10 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [28:0] quotient
);
    localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
    localparam int          SHIFT = 35;

    logic        go_reg,    go_next;
    logic        done_reg,  done_next;
    logic [31:0] x_reg,     x_next;
    logic [63:0] prod_reg,  prod_next;

    always_comb
    begin
        go_next   = start;
        done_next = go_reg;
        x_next    = start ? dividend : x_reg;
        prod_next = go_reg ? (64'(x_reg) * 64'(RECIP)) : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
            x_reg    <= '0;
            prod_reg <= '0;
        end
        else
        begin
            go_reg   <= go_next;
            done_reg <= done_next;
            x_reg    <= x_next;
            prod_reg <= prod_next;
        end
    end

    assign done     = done_reg;
    assign quotient = prod_reg[SHIFT +: 29];
endmodule

@@ design/obd_diag_response_parser_top.sv @@
// Diagnostic response parser: takes one reassembled response byte per request, with an
// end-of-message mark, or a clear request that empties the stored trouble code list. OBD
// 0x43 replies yield two-byte codes until a 00 00 pair, UDS 0x59/0x02 replies yield
// three-byte codes from four-byte records, 0x41 A6 sets the mileage to raw/10 and 0x49 02
// yields up to VIN_MAX_CHARS printable characters and a completion result. A new code walks
// a row of MAX_CODES compare cells, one cell per cycle; the last odometer byte goes to the
// divide-by-ten unit, a registered multiply by a fixed reciprocal. Results leave through an
// output register, so the next request is taken while a result still waits there.
module obd_diag_response_parser_top #(
    parameter int MAX_CODES         = 32,
    parameter int VIN_MAX_CHARS     = 19,
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    odrp_chan_if.sink   request,
    odrp_chan_if.source result
);
    import odrp_pkg::*;

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_CODES + 1);
    localparam int VL_W  = $clog2(VIN_MAX_CHARS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV} state_t;

    state_t             state_reg,     state_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [7:0]         svc_reg,       svc_next;
    logic [7:0]         sb_reg,        sb_next;
    logic               ps_reg,        ps_next;
    logic [23:0]        rh_reg,        rh_next;
    logic [23:0]        oh_reg,        oh_next;
    logic [28:0]        mil_reg,       mil_next;
    logic [CNT_W-1:0]   cnt_reg,       cnt_next;
    logic [VL_W-1:0]    vl_reg,        vl_next;
    res_t               pend_reg [2];
    res_t               pend_next [2];
    logic [1:0]         pend_cnt_reg,  pend_cnt_next;
    res_t               out_reg,       out_next;
    logic               out_valid_reg, out_valid_next;

    logic               req_fire;
    logic               pos_zero;
    logic               in_range;
    logic [7:0]         b;
    logic [7:0]         svc_eff;
    logic [7:0]         sb_eff;
    logic               ps_eff;
    logic [23:0]        rh_eff;
    logic [23:0]        oh_eff;
    logic [VL_W-1:0]    vl_eff;
    logic [VL_W-1:0]    vl_inc;
    logic [15:0]        pair;
    logic [1:0]         phase;
    logic               is_obd, is_uds, is_odo, is_vin;
    logic               printable;
    logic               vin_char, vin_done;
    logic [CNT_W-1:0]   cnt_inc;
    logic               code_add;
    res_t               char_res, done_res;

    probe_t             chain [MAX_CODES + 1];
    probe_t             probe_head;
    probe_t             chain_out;
    logic [MAX_CODES-1:0] cell_active;
    logic [MAX_CODES-1:0] cell_we;
    logic               div_start;
    logic               div_done;
    logic [28:0]        div_quot;

    function automatic res_t mk_res(
        input logic [1:0]  ev,
        input logic        kind,
        input logic [23:0] value,
        input logic [5:0]  total,
        input logic [28:0] mil,
        input logic [4:0]  vpos,
        input logic [6:0]  vch,
        input logic [4:0]  vcnt,
        input logic        last
    );
        res_t r;
        r.event_res     = ev;
        r.code_kind     = kind;
        r.code_value    = value;
        r.code_total    = total;
        r.mileage_value = mil;
        r.vin_position  = vpos;
        r.vin_character = vch;
        r.vin_count     = vcnt;
        r.run_last      = last;
        return r;
    endfunction

    assign request.ready = (state_reg == S_IDLE) && (pend_cnt_reg == 2'd0);
    assign req_fire      = request.valid && request.ready;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_reg;

    assign b        = request.payload.payload_byte;
    assign pos_zero = pos_reg == '0;
    assign in_range = pos_reg < POS_W'(MAX_MESSAGE_BYTES);
    assign svc_eff  = pos_zero ? b : svc_reg;
    assign sb_eff   = pos_zero ? 8'd0 : ((pos_reg == POS_W'(1)) ? b : sb_reg);
    assign ps_eff   = pos_zero ? 1'b0 : ps_reg;
    assign rh_eff   = pos_zero ? 24'd0 : rh_reg;
    assign oh_eff   = pos_zero ? 24'd0 : oh_reg;
    assign vl_eff   = pos_zero ? '0 : vl_reg;
    assign vl_inc   = vl_eff + VL_W'(1);
    assign pair     = {rh_eff[7:0], b};
    assign phase    = pos_reg[1:0] - 2'd3;
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    assign is_obd = svc_eff == SVC_OBD_DTC;
    assign is_uds = (svc_eff == (SVC_UDS_DTC + SVC_POS_OFFSET)) && (sb_eff == UDS_DTC_BY_MASK);
    assign is_odo = (svc_eff == SVC_OBD_DATA) && (sb_eff == PID_ODOMETER);
    assign is_vin = (svc_eff == SVC_VEH_INFO) && (sb_eff == INFO_VIN);
    assign printable = (b > VIN_CHAR_LO) && (b <= VIN_CHAR_HI);

    assign vin_char = in_range && is_vin && (pos_reg >= POS_W'(3))
                      && (vl_eff < VL_W'(VIN_MAX_CHARS)) && printable;
    assign vin_done = request.payload.end_of_message && is_vin && (pos_reg >= POS_W'(2));

    assign chain[0]  = probe_head;
    assign chain_out = chain[MAX_CODES];
    assign code_add  = (state_reg == S_SCAN) && chain_out.valid && !chain_out.hit
                       && (cnt_reg < CNT_W'(MAX_CODES));

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CODES; gi++)
        begin : g_cell
            assign cell_active[gi] = CNT_W'(gi) < cnt_reg;
            assign cell_we[gi]     = code_add && (cnt_reg == CNT_W'(gi));
            odrp_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .active    (cell_active[gi]),
                .wr_en     (cell_we[gi]),
                .wr_entry  (chain_out.entry),
                .probe_in  (chain[gi]),
                .probe_out (chain[gi+1])
            );
        end
    endgenerate

    odrp_div10 u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({oh_eff, b}),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        char_res = mk_res(EV_VIN_CHAR, KIND_OBD, 24'd0, 6'(cnt_reg), 29'd0, 5'(vl_eff),
                          b[6:0], 5'(vl_inc), !vin_done);
        done_res = mk_res(EV_VIN_COMPLETE, KIND_OBD, 24'd0, 6'(cnt_reg), 29'd0, 5'd0,
                          7'd0, vin_char ? 5'(vl_inc) : 5'(vl_eff), 1'b1);
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        svc_next       = svc_reg;
        sb_next        = sb_reg;
        ps_next        = ps_reg;
        rh_next        = rh_reg;
        oh_next        = oh_reg;
        mil_next       = mil_reg;
        cnt_next       = cnt_reg;
        vl_next        = vl_reg;
        pend_next[0]   = pend_reg[0];
        pend_next[1]   = pend_reg[1];
        pend_cnt_next  = pend_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        probe_head     = '0;
        div_start      = 1'b0;

        // drain pending results into the output register
        if (pend_cnt_reg != 2'd0 && (!out_valid_reg || result.ready))
        begin
            out_next       = pend_reg[0];
            out_valid_next = 1'b1;
            pend_next[0]   = pend_reg[1];
            pend_cnt_next  = pend_cnt_reg - 2'd1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (request.payload.op == OP_CLEAR)
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        if (in_range)
                        begin
                            svc_next = svc_eff;
                            sb_next  = sb_eff;
                            ps_next  = ps_eff;
                            rh_next  = rh_eff;
                            oh_next  = oh_eff;
                            vl_next  = vin_char ? vl_inc : vl_eff;
                            pos_next = pos_reg + POS_W'(1);
                            if (is_obd && !pos_zero && !ps_eff)
                            begin
                                if (pos_reg[0])
                                begin
                                    rh_next = {16'd0, b};
                                end
                                else if (pair == 16'd0)
                                begin
                                    ps_next = 1'b1;
                                end
                                else
                                begin
                                    probe_head.valid = 1'b1;
                                    probe_head.entry = {KIND_OBD, 8'd0, pair};
                                    state_next       = S_SCAN;
                                end
                            end
                            if (is_uds && pos_reg >= POS_W'(3))
                            begin
                                if (phase != 2'd3)
                                begin
                                    rh_next = {rh_eff[15:0], b};
                                end
                                else
                                begin
                                    probe_head.valid = 1'b1;
                                    probe_head.entry = {KIND_UDS, rh_eff};
                                    state_next       = S_SCAN;
                                end
                            end
                            if (is_odo && pos_reg >= POS_W'(2) && pos_reg <= POS_W'(5))
                            begin
                                if (pos_reg < POS_W'(5))
                                begin
                                    oh_next = {oh_eff[15:0], b};
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        if (request.payload.end_of_message)
                        begin
                            pos_next = '0;
                        end
                        priority if (vin_char && vin_done)
                        begin
                            pend_next[0]  = char_res;
                            pend_next[1]  = done_res;
                            pend_cnt_next = 2'd2;
                        end
                        else if (vin_char)
                        begin
                            pend_next[0]  = char_res;
                            pend_cnt_next = 2'd1;
                        end
                        else if (vin_done)
                        begin
                            pend_next[0]  = done_res;
                            pend_cnt_next = 2'd1;
                        end
                        else
                        begin
                            pend_cnt_next = pend_cnt_reg;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (chain_out.valid)
                begin
                    state_next = S_IDLE;
                    if (code_add)
                    begin
                        cnt_next      = cnt_inc;
                        pend_next[0]  = mk_res(EV_CODE_ADDED, chain_out.entry[24],
                                               chain_out.entry[23:0], 6'(cnt_inc), 29'd0,
                                               5'd0, 7'd0, 5'd0, 1'b1);
                        pend_cnt_next = 2'd1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next    = S_IDLE;
                    mil_next      = div_quot;
                    pend_next[0]  = mk_res(EV_MILEAGE, KIND_OBD, 24'd0, 6'(cnt_reg), div_quot,
                                           5'd0, 7'd0, 5'd0, 1'b1);
                    pend_cnt_next = 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            svc_reg       <= '0;
            sb_reg        <= '0;
            ps_reg        <= 1'b0;
            rh_reg        <= '0;
            oh_reg        <= '0;
            mil_reg       <= '0;
            cnt_reg       <= '0;
            vl_reg        <= '0;
            pend_reg[0]   <= '0;
            pend_reg[1]   <= '0;
            pend_cnt_reg  <= 2'd0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            svc_reg       <= svc_next;
            sb_reg        <= sb_next;
            ps_reg        <= ps_next;
            rh_reg        <= rh_next;
            oh_reg        <= oh_next;
            mil_reg       <= mil_next;
            cnt_reg       <= cnt_next;
            vl_reg        <= vl_next;
            pend_reg[0]   <= pend_next[0];
            pend_reg[1]   <= pend_next[1];
            pend_cnt_reg  <= pend_cnt_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CODES))
        else $error("code count beyond list size");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its state");

    a_probe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> state_reg == S_SCAN)
        else $error("probe left the cell row outside a scan");

    a_pending_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd0 |-> state_reg == S_IDLE && pend_cnt_reg != 2'd3)
        else $error("pending results while busy");

    a_eom_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && request.payload.op == OP_BYTE && request.payload.end_of_message
        |=> pos_reg == '0)
        else $error("end of message did not rewind the byte position");
endmodule

@@ tb/tb.sv @@
module tb;
    import odrp_pkg::*;

    localparam int CODE_SLOTS    = 32;
    localparam int VIN_SLOTS     = 19;
    localparam int MESSAGE_LIMIT = 256;
    localparam int PHASE_ITEMS   = 150;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [7:0] SVC_NEGATIVE = 8'h7F;
    localparam logic [7:0] SVC_UDS_POS  = SVC_UDS_DTC + SVC_POS_OFFSET;

    localparam int SEND_IDLE[4] = '{0, 49, 0, 21};
    localparam int RECV_STALL[4] = '{0, 0, 49, 21};

    logic clk;
    logic rst_n;

    odrp_chan_if #(.payload_t(req_t)) request_if ();
    odrp_chan_if #(.payload_t(res_t)) result_if ();

    obd_diag_response_parser_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // parser state as the block should hold it
    logic [8:0]  byte_position;
    logic [7:0]  service_code;
    logic [7:0]  second_byte;
    logic        pairs_stopped;
    logic [23:0] record_hold;
    logic [23:0] odometer_hold;
    logic [28:0] mileage_store;
    logic [24:0] code_list [CODE_SLOTS];
    logic [5:0]  code_count;
    logic [4:0]  vin_length;

    req_t        pending_requests[$];
    res_t        expected_events[$];
    logic [7:0]  draft[$];
    logic [23:0] code_pool [8];

    int idle_pct;
    int stall_pct;
    int items_queued;
    int requests_offered;
    int requests_taken;
    int quiet_cycles;
    int mismatches;

    function automatic res_t blank_event(input logic [1:0] kind);
        res_t r;
        r = '0;
        r.event_res = kind;
        r.code_total = code_count;
        return r;
    endfunction

    function automatic bit store_code(input logic kind, input logic [23:0] value);
        logic [24:0] entry;
        int i;
        entry = {kind, value};
        if (code_count >= CODE_SLOTS)
            return 1'b0;
        for (i = 0; i < code_count; i++)
            if (code_list[i] == entry)
                return 1'b0;
        code_list[code_count] = entry;
        code_count = code_count + 1'b1;
        return 1'b1;
    endfunction

    task automatic parse_request(input req_t r);
        res_t        produced[$];
        res_t        ev;
        logic [8:0]  p;
        logic [8:0]  phase;
        logic [7:0]  b;
        logic [15:0] pair;
        logic [31:0] raw;
        logic [31:0] quotient;
        int          i;
        p = byte_position;
        b = r.payload_byte;
        if (r.op == OP_CLEAR)
        begin
            code_count = '0;
        end
        else
        begin
            if (p < MESSAGE_LIMIT)
            begin
                if (p == 0)
                begin
                    service_code = b;
                    second_byte = '0;
                    pairs_stopped = 1'b0;
                    record_hold = '0;
                    odometer_hold = '0;
                    vin_length = '0;
                end
                else if (p == 1)
                begin
                    second_byte = b;
                end

                if (service_code == SVC_OBD_DTC && p >= 1 && !pairs_stopped)
                begin
                    if (p[0])
                    begin
                        record_hold = {16'h0, b};
                    end
                    else
                    begin
                        pair = {record_hold[7:0], b};
                        if (pair == 16'h0)
                        begin
                            pairs_stopped = 1'b1;
                        end
                        else if (store_code(KIND_OBD, {8'h0, pair}))
                        begin
                            ev = blank_event(EV_CODE_ADDED);
                            ev.code_kind = KIND_OBD;
                            ev.code_value = {8'h0, pair};
                            produced.push_back(ev);
                        end
                    end
                end

                if (service_code == SVC_UDS_POS && second_byte == UDS_DTC_BY_MASK && p >= 3)
                begin
                    phase = p - 9'd3;
                    if (phase[1:0] != 2'd3)
                    begin
                        record_hold = {record_hold[15:0], b};
                    end
                    else if (store_code(KIND_UDS, record_hold))
                    begin
                        ev = blank_event(EV_CODE_ADDED);
                        ev.code_kind = KIND_UDS;
                        ev.code_value = record_hold;
                        produced.push_back(ev);
                    end
                end

                if (service_code == SVC_OBD_DATA && second_byte == PID_ODOMETER
                        && p >= 2 && p <= 5)
                begin
                    if (p < 5)
                    begin
                        odometer_hold = {odometer_hold[15:0], b};
                    end
                    else
                    begin
                        raw = {odometer_hold, b};
                        quotient = raw / 10;
                        mileage_store = quotient[28:0];
                        ev = blank_event(EV_MILEAGE);
                        ev.mileage_value = mileage_store;
                        produced.push_back(ev);
                    end
                end

                if (service_code == SVC_VEH_INFO && second_byte == INFO_VIN && p >= 3
                        && vin_length < VIN_SLOTS && b > VIN_CHAR_LO && b <= VIN_CHAR_HI)
                begin
                    ev = blank_event(EV_VIN_CHAR);
                    ev.vin_position = vin_length;
                    ev.vin_character = b[6:0];
                    vin_length = vin_length + 1'b1;
                    ev.vin_count = vin_length;
                    produced.push_back(ev);
                end

                byte_position = p + 1'b1;
            end

            if (r.end_of_message)
            begin
                if (service_code == SVC_VEH_INFO && second_byte == INFO_VIN && p >= 2)
                begin
                    ev = blank_event(EV_VIN_COMPLETE);
                    ev.vin_count = vin_length;
                    produced.push_back(ev);
                end
                byte_position = '0;
            end

            if (produced.size() > 0)
            begin
                ev = produced.pop_back();
                ev.run_last = 1'b1;
                produced.push_back(ev);
            end
            for (i = 0; i < produced.size(); i++)
                expected_events.push_back(produced[i]);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [23:0] pick_code();
        if ($urandom_range(1) == 0)
            return code_pool[$urandom_range(7)];
        return 24'($urandom);
    endfunction

    function automatic string describe(input res_t r);
        return $sformatf({"ev=%0d kind=%0d code=%06h total=%0d miles=%0d ",
                          "pos=%0d chr=%02h cnt=%0d last=%0d"},
                         r.event_res, r.code_kind, r.code_value, r.code_total, r.mileage_value,
                         r.vin_position, r.vin_character, r.vin_count, r.run_last);
    endfunction

    task automatic push_clear();
        req_t r;
        r.op = OP_CLEAR;
        r.payload_byte = rand_byte();
        r.end_of_message = 1'($urandom_range(1));
        pending_requests.push_back(r);
        items_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eom);
        req_t r;
        if ($urandom_range(199) == 0)
            push_clear();
        r.op = OP_BYTE;
        r.payload_byte = b;
        r.end_of_message = eom;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    task automatic send_draft();
        int i;
        for (i = 0; i < draft.size(); i++)
            push_byte(draft[i], i == draft.size() - 1);
        draft.delete();
    endtask

    task automatic draft_overlong();
        int         length;
        logic [7:0] svc;
        length = $urandom_range(MESSAGE_LIMIT + 1, MESSAGE_LIMIT + 8);
        case ($urandom_range(2))
            0: svc = SVC_OBD_DTC;
            1: svc = SVC_UDS_POS;
            default: svc = SVC_VEH_INFO;
        endcase
        draft.push_back(svc);
        if (svc != SVC_OBD_DTC)
            draft.push_back(INFO_VIN);
        while (draft.size() < length)
            draft.push_back(rand_byte());
    endtask

    task automatic draft_random_message();
        int          pick;
        int          n;
        int          i;
        int          extreme;
        logic [23:0] code;
        logic [7:0]  b;
        pick = $urandom_range(18);
        if (pick <= 5)
        begin
            draft.push_back(SVC_OBD_DTC);
            n = $urandom_range(8);
            for (i = 0; i < n; i++)
            begin
                code = pick_code();
                draft.push_back(code[15:8]);
                draft.push_back(code[7:0]);
            end
            if ($urandom_range(3) == 0)
            begin
                draft.push_back(8'h00);
                draft.push_back(8'h00);
                n = $urandom_range(4);
                for (i = 0; i < n; i++)
                    draft.push_back(rand_byte());
            end
            if ($urandom_range(5) == 0)
                draft.push_back(rand_byte());
        end
        else if (pick <= 9)
        begin
            draft.push_back(SVC_UDS_POS);
            if ($urandom_range(9) != 0)
            begin
                draft.push_back($urandom_range(4) == 0 ? rand_byte() : UDS_DTC_BY_MASK);
                draft.push_back(rand_byte());
                n = $urandom_range(5);
                for (i = 0; i < n; i++)
                begin
                    code = pick_code();
                    draft.push_back(code[23:16]);
                    draft.push_back(code[15:8]);
                    draft.push_back(code[7:0]);
                    draft.push_back(rand_byte());
                end
                n = $urandom_range(3);
                for (i = 0; i < n; i++)
                    draft.push_back(rand_byte());
            end
        end
        else if (pick <= 11)
        begin
            draft.push_back(SVC_OBD_DATA);
            draft.push_back($urandom_range(4) == 0 ? rand_byte() : PID_ODOMETER);
            extreme = $urandom_range(5);
            n = ($urandom_range(5) == 0) ? $urandom_range(3) : 4;
            for (i = 0; i < n; i++)
            begin
                b = rand_byte();
                if (extreme == 1)
                    b = 8'hFF;
                else if (extreme == 2)
                    b = 8'h00;
                draft.push_back(b);
            end
            if ($urandom_range(3) == 0)
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    draft.push_back(rand_byte());
            end
        end
        else if (pick <= 15)
        begin
            draft.push_back(SVC_VEH_INFO);
            if ($urandom_range(11) != 0)
            begin
                draft.push_back($urandom_range(5) == 0 ? rand_byte() : INFO_VIN);
                if ($urandom_range(11) != 0)
                begin
                    draft.push_back(rand_byte());
                    n = $urandom_range(12, 24);
                    for (i = 0; i < n; i++)
                    begin
                        case ($urandom_range(9))
                            0: b = 8'h00;
                            1: b = VIN_CHAR_LO;
                            2: b = rand_byte();
                            default: b = 8'($urandom_range(VIN_CHAR_LO + 1, VIN_CHAR_HI));
                        endcase
                        draft.push_back(b);
                    end
                end
            end
        end
        else if (pick <= 17)
        begin
            draft.push_back($urandom_range(3) == 0 ? SVC_NEGATIVE : rand_byte());
            n = $urandom_range(8);
            for (i = 0; i < n; i++)
                draft.push_back(rand_byte());
        end
        else
        begin
            push_clear();
        end
    endtask

    task automatic flag_result(input string detail);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", detail);
    endtask

    // hold a request until taken, then offer the next one
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            request_if.valid <= 1'b0;
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= ($urandom_range(99) >= stall_pct);
            if (requests_offered == requests_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    request_if.payload <= pending_requests.pop_front();
                    request_if.valid <= 1'b1;
                    requests_offered++;
                end
                else
                begin
                    request_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        res_t want;
        res_t got;
        logic moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (request_if.valid && request_if.ready)
            begin
                parse_request(request_if.payload);
                requests_taken++;
                moved = 1'b1;
            end
            if (result_if.valid && result_if.ready)
            begin
                moved = 1'b1;
                got = result_if.payload;
                if (expected_events.size() == 0)
                begin
                    flag_result($sformatf("unexpected result: %s", describe(got)));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got.event_res !== want.event_res || got.code_kind !== want.code_kind
                            || got.code_value !== want.code_value
                            || got.code_total !== want.code_total
                            || got.mileage_value !== want.mileage_value
                            || got.vin_position !== want.vin_position
                            || got.vin_character !== want.vin_character
                            || got.vin_count !== want.vin_count
                            || got.run_last !== want.run_last)
                        flag_result($sformatf("mismatch: expected %s, got %s",
                                              describe(want), describe(got)));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int target;
        int i;
        rst_n = 1'b0;
        request_if.valid = 1'b0;
        request_if.payload = '0;
        result_if.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        items_queued = 0;
        requests_offered = 0;
        requests_taken = 0;
        quiet_cycles = 0;
        mismatches = 0;
        byte_position = '0;
        service_code = '0;
        second_byte = '0;
        pairs_stopped = 1'b0;
        record_hold = '0;
        odometer_hold = '0;
        mileage_store = '0;
        code_count = '0;
        vin_length = '0;
        for (i = 0; i < 8; i++)
            code_pool[i] = 24'($urandom);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = SEND_IDLE[phase];
            stall_pct = RECV_STALL[phase];
            if (phase == 0)
            begin
                draft = {SVC_OBD_DTC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAB};
                send_draft();
                draft = {SVC_OBD_DATA, PID_ODOMETER, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                send_draft();
                push_clear();
                draft = {SVC_UDS_POS, UDS_DTC_BY_MASK, 8'hFF, 8'hAA, 8'hBB, 8'hCC, 8'h00};
                send_draft();
                draft = {SVC_VEH_INFO, INFO_VIN, 8'h00, VIN_CHAR_LO, SVC_NEGATIVE,
                         VIN_CHAR_LO + 8'h01, VIN_CHAR_HI};
                send_draft();
            end
            if (phase == 2)
            begin
                draft_overlong();
                send_draft();
            end
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
            begin
                draft_random_message();
                send_draft();
            end
            while (pending_requests.size() != 0 || requests_offered != requests_taken
                    || expected_events.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (mismatches == 0 && expected_events.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
design/odrp_pkg.sv
design/odrp_chan_if.sv
design/odrp_cell.sv
design/odrp_div10.sv
design/obd_diag_response_parser_top.sv
tb/tb.sv
